[rtl/vector2d_direction_normalize_top_macros.svh]
// Assertion macros for the direction normalise block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef VECTOR2D_DIRECTION_NORMALIZE_TOP_MACROS_SVH
`define VECTOR2D_DIRECTION_NORMALIZE_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define VDN_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define VDN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/vdn_pkg.sv]
// Shared widths and constants for the direction normalise block.
// No dependencies.
package vdn_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_OUT        = 30;
	localparam int NORM_W          = 31;
	localparam int RAD_W           = 64;
	localparam int ROOT_W          = 32;
	localparam int QUOT_W          = 31;
	localparam int NUM_W           = 62;
	localparam int OUT_W           = 32;
endpackage

[rtl/vdn_sqrt_pipe.sv]
// Pipelined restoring integer square root, one root bit per stage.
// Depends on vdn_pkg; carries a sideband word and valid bit alongside.
module vdn_sqrt_pipe #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [vdn_pkg::RAD_W-1:0]     rad,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_vld,
	output logic [vdn_pkg::ROOT_W-1:0]    root,
	output logic [SIDE_W-1:0]             out_side
);
	import vdn_pkg::*;

	logic [ROOT_W+1:0]  rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0]  root_s [0:ROOT_W-1];
	logic [RAD_W-1:0]   rad_s  [0:ROOT_W-1];
	logic [SIDE_W-1:0]  side_s [0:ROOT_W-1];
	logic               vld_s  [0:ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
		logic [ROOT_W+1:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		logic [SIDE_W-1:0] side_in;
		logic              vld_in;
		logic [ROOT_W+1:0] cat;
		logic [ROOT_W+1:0] trial;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		assign cat   = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1-2*k -: 2]};
		assign trial = {root_in, 2'b01};
		assign take  = (cat >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? (cat - trial) : cat;
				root_s[k] <= {root_in[ROOT_W-2:0], take};
				rad_s[k]  <= rad_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign root     = root_s[ROOT_W-1];
	assign out_side = side_s[ROOT_W-1];
endmodule

[rtl/vdn_div_pipe.sv]
// Pipelined restoring divider for two dividends over one divisor,
// one quotient bit per stage. Depends on vdn_pkg.
module vdn_div_pipe #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [vdn_pkg::ROOT_W-1:0]    dvs,
	input  logic [vdn_pkg::NUM_W-1:0]     num_x,
	input  logic [vdn_pkg::NUM_W-1:0]     num_y,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_vld,
	output logic [vdn_pkg::QUOT_W-1:0]    quo_x,
	output logic [vdn_pkg::QUOT_W-1:0]    quo_y,
	output logic [SIDE_W-1:0]             out_side
);
	import vdn_pkg::*;

	logic [ROOT_W-1:0] remx_s [0:QUOT_W-1];
	logic [ROOT_W-1:0] remy_s [0:QUOT_W-1];
	logic [QUOT_W-1:0] qx_s   [0:QUOT_W-1];
	logic [QUOT_W-1:0] qy_s   [0:QUOT_W-1];
	logic [NUM_W-1:0]  nx_s   [0:QUOT_W-1];
	logic [NUM_W-1:0]  ny_s   [0:QUOT_W-1];
	logic [ROOT_W-1:0] d_s    [0:QUOT_W-1];
	logic [SIDE_W-1:0] side_s [0:QUOT_W-1];
	logic              vld_s  [0:QUOT_W-1];

	for (genvar k = 0; k < QUOT_W; k++) begin : g_stg
		logic [ROOT_W-1:0] rx_in, ry_in, d_in;
		logic [QUOT_W-1:0] qx_in, qy_in;
		logic [NUM_W-1:0]  nx_in, ny_in;
		logic [SIDE_W-1:0] side_in;
		logic              vld_in;
		logic [ROOT_W:0]   catx, caty, dext;
		logic              takex, takey;

		if (k == 0) begin : g_first
			assign rx_in   = {1'b0, num_x[NUM_W-1:QUOT_W]};
			assign ry_in   = {1'b0, num_y[NUM_W-1:QUOT_W]};
			assign d_in    = dvs;
			assign qx_in   = '0;
			assign qy_in   = '0;
			assign nx_in   = num_x;
			assign ny_in   = num_y;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign rx_in   = remx_s[k-1];
			assign ry_in   = remy_s[k-1];
			assign d_in    = d_s[k-1];
			assign qx_in   = qx_s[k-1];
			assign qy_in   = qy_s[k-1];
			assign nx_in   = nx_s[k-1];
			assign ny_in   = ny_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		assign dext  = {1'b0, d_in};
		assign catx  = {rx_in, nx_in[QUOT_W-1-k]};
		assign caty  = {ry_in, ny_in[QUOT_W-1-k]};
		assign takex = (catx >= dext);
		assign takey = (caty >= dext);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remx_s[k] <= takex ? ROOT_W'(catx - dext) : catx[ROOT_W-1:0];
				remy_s[k] <= takey ? ROOT_W'(caty - dext) : caty[ROOT_W-1:0];
				qx_s[k]   <= {qx_in[QUOT_W-2:0], takex};
				qy_s[k]   <= {qy_in[QUOT_W-2:0], takey};
				nx_s[k]   <= nx_in;
				ny_s[k]   <= ny_in;
				d_s[k]    <= d_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[QUOT_W-1];
	assign quo_x    = qx_s[QUOT_W-1];
	assign quo_y    = qy_s[QUOT_W-1];
	assign out_side = side_s[QUOT_W-1];
endmodule

[rtl/vector2d_direction_normalize_top.sv]
// Unit direction between two 2-D points, Q16.16 in, Q2.30 out.
// Depends on vdn_pkg, vdn_sqrt_pipe and vdn_div_pipe.
//
// Input channel: item_valid / item_stall with origin and target coordinates.
// Output channel: result_valid / result_stall with unit_x, unit_y and
// zero_length (set when the points coincide, components then zero).
// One result per input beat, in order.
// Pipeline from accepting a beat to its result showing: six front stages
// (difference, magnitude, bit length, shift, square, sum),
// the 32-stage square root, one dividend stage, the 31-stage divider and
// the output register.
// Throughput: one beat per cycle while the output is not stalled.
// Stall: while a result is shown and result_stall is high the whole pipe
// holds and item_stall is raised in the same cycle; nothing is lost.
// Reset: arst_n clears every valid bit; the pipe then starts empty and
// accepts beats straight after release.
module vector2d_direction_normalize_top #(
	parameter int COORD_WIDTH = vdn_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic signed [COORD_WIDTH-1:0]      origin_x,
	input  logic signed [COORD_WIDTH-1:0]      origin_y,
	input  logic signed [COORD_WIDTH-1:0]      target_x,
	input  logic signed [COORD_WIDTH-1:0]      target_y,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [vdn_pkg::OUT_W-1:0]   unit_x,
	output logic signed [vdn_pkg::OUT_W-1:0]   unit_y,
	output logic                               zero_length
);
	import vdn_pkg::*;

	localparam int AW    = COORD_WIDTH;
	localparam int BLW   = $clog2(AW + 1);
	localparam int WIDEW = AW + NORM_W;
	localparam int SQW   = 2 * NORM_W;
	localparam int SUMW  = SQW + 1;
	localparam int SQ_SIDE = 2 * NORM_W + 3;
	localparam int DV_SIDE = 3;

	logic en;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [AW:0]   dx_s1, dy_s1;
	logic [AW-1:0]        ax_s2, ay_s2, ax_s3, ay_s3;
	logic [BLW-1:0]       bl_s3;
	logic [NORM_W-1:0]    ax_s4, ay_s4, ax_s5, ay_s5, ax_s6, ay_s6;
	logic [SQW-1:0]       sqx_s5, sqy_s5;
	logic [SUMW-1:0]      sum_s6;
	logic                 nx_s2, ny_s2, zero_s2;
	logic                 nx_s3, ny_s3, zero_s3;
	logic                 nx_s4, ny_s4, zero_s4;
	logic                 nx_s5, ny_s5, zero_s5;
	logic                 nx_s6, ny_s6, zero_s6;
	logic [NUM_W-1:0]     numx_s7, numy_s7;
	logic [ROOT_W-1:0]    len_s7;
	logic [DV_SIDE-1:0]   side_s7;
	logic                 out_valid_q;

	logic [AW-1:0]        ax_c, ay_c, m_c;
	logic [BLW-1:0]       bl_c;
	logic [WIDEW-1:0]     shx_c, shy_c;

	logic                 sq_vld;
	logic [ROOT_W-1:0]    sq_root;
	logic [SQ_SIDE-1:0]   sq_side;
	logic                 dv_vld;
	logic [QUOT_W-1:0]    dv_qx, dv_qy;
	logic [DV_SIDE-1:0]   dv_side;
	logic [OUT_W-1:0]     ext_x, ext_y;

	assign en         = !(out_valid_q && result_stall);
	assign item_stall = !en;

	always_comb begin
		ax_c = dx_s1[AW] ? AW'(-dx_s1) : dx_s1[AW-1:0];
		ay_c = dy_s1[AW] ? AW'(-dy_s1) : dy_s1[AW-1:0];
	end

	assign m_c = (ax_s2 > ay_s2) ? ax_s2 : ay_s2;

	always_comb begin
		bl_c = '0;
		for (int i = 0; i < AW; i++) begin
			if (m_c[i]) begin
				bl_c = BLW'(i + 1);
			end
		end
	end

	assign shx_c = {ax_s3, {NORM_W{1'b0}}} >> bl_s3;
	assign shy_c = {ay_s3, {NORM_W{1'b0}}} >> bl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= item_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			vld_s7      <= sq_vld;
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= $signed({origin_x[AW-1], origin_x}) - $signed({target_x[AW-1], target_x});
			dy_s1   <= $signed({origin_y[AW-1], origin_y}) - $signed({target_y[AW-1], target_y});
			ax_s2   <= ax_c;
			ay_s2   <= ay_c;
			nx_s2   <= dx_s1[AW];
			ny_s2   <= dy_s1[AW];
			zero_s2 <= (ax_c == '0) && (ay_c == '0);
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			bl_s3   <= bl_c;
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;
			zero_s3 <= zero_s2;
			ax_s4   <= shx_c[NORM_W-1:0];
			ay_s4   <= shy_c[NORM_W-1:0];
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			zero_s4 <= zero_s3;
			sqx_s5  <= ax_s4 * ax_s4;
			sqy_s5  <= ay_s4 * ay_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
			zero_s5 <= zero_s4;
			sum_s6  <= {1'b0, sqx_s5} + {1'b0, sqy_s5};
			ax_s6   <= ax_s5;
			ay_s6   <= ay_s5;
			nx_s6   <= nx_s5;
			ny_s6   <= ny_s5;
			zero_s6 <= zero_s5;
			len_s7  <= sq_root;
			numx_s7 <= NUM_W'({sq_side[SQ_SIDE-1 -: NORM_W], {FRAC_OUT{1'b0}}})
				+ NUM_W'(sq_root >> 1);
			numy_s7 <= NUM_W'({sq_side[NORM_W+2 -: NORM_W], {FRAC_OUT{1'b0}}})
				+ NUM_W'(sq_root >> 1);
			side_s7 <= sq_side[DV_SIDE-1:0];
			unit_x  <= dv_side[0] ? '0 : (dv_side[2] ? -ext_x : ext_x);
			unit_y  <= dv_side[0] ? '0 : (dv_side[1] ? -ext_y : ext_y);
			zero_length <= dv_side[0];
		end
	end

	vdn_sqrt_pipe #(
		.SIDE_W(SQ_SIDE)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.rad      ({{(RAD_W-SUMW){1'b0}}, sum_s6}),
		.in_side  ({ax_s6, ay_s6, nx_s6, ny_s6, zero_s6}),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	vdn_div_pipe #(
		.SIDE_W(DV_SIDE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s7),
		.dvs      (len_s7),
		.num_x    (numx_s7),
		.num_y    (numy_s7),
		.in_side  (side_s7),
		.out_vld  (dv_vld),
		.quo_x    (dv_qx),
		.quo_y    (dv_qy),
		.out_side (dv_side)
	);

	assign ext_x = {{(OUT_W-QUOT_W){1'b0}}, dv_qx};
	assign ext_y = {{(OUT_W-QUOT_W){1'b0}}, dv_qy};

	assign result_valid = out_valid_q;
endmodule

[rtl/vdn_checker.sv]
// Port checker for the direction normalise block, bound to the top level.
// Depends on vdn_pkg and vector2d_direction_normalize_top_macros.svh.
`include "vector2d_direction_normalize_top_macros.svh"

module vdn_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_stall,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  logic signed [vdn_pkg::OUT_W-1:0]   unit_x,
	input  logic signed [vdn_pkg::OUT_W-1:0]   unit_y,
	input  logic                               zero_length
);
	import vdn_pkg::*;

	localparam logic signed [OUT_W-1:0] ONE_POS = OUT_W'(1) << FRAC_OUT;
	localparam logic signed [OUT_W-1:0] ONE_NEG = -ONE_POS;

	`VDN_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(unit_x) && $stable(unit_y) && $stable(zero_length), "stalled result changed")
	`VDN_ASSERT(a_stall_src, 1'b1, item_stall == (result_valid && result_stall), "input stall not tied to output stall")
	`VDN_ASSERT(a_zero, result_valid && zero_length, unit_x == '0 && unit_y == '0, "zero length with nonzero components")
	`VDN_ASSERT(a_range, result_valid, unit_x <= ONE_POS && unit_x >= ONE_NEG && unit_y <= ONE_POS && unit_y >= ONE_NEG, "component beyond unit range")
endmodule

bind vector2d_direction_normalize_top vdn_checker u_vdn_checker (.*);

[tb/sv/vector2d_direction_normalize_top_tb.sv]
// Testbench for vector2d_direction_normalize_top: drives point pairs and checks unit directions.
// An internal normaliser predicts each result; a small scoreboard class compares them in order.
// Depends on vdn_pkg and the RTL of the block.
module vector2d_direction_normalize_top_tb;
	import vdn_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int LATENCY = 71;
	localparam int N_RANDOM = 1200;

	typedef struct packed {
		logic [OUT_W-1:0] ux;
		logic [OUT_W-1:0] uy;
		logic             zl;
	} direction_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic signed [CW-1:0] origin_x = '0, origin_y = '0, target_x = '0, target_y = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [OUT_W-1:0] unit_x, unit_y;
	logic zero_length;

	int errors = 0;
	int n_beats = 0;
	int n_zero = 0;
	bit quiet = 1'b0;

	always #4 clk = ~clk;

	vector2d_direction_normalize_top u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.origin_x(origin_x), .origin_y(origin_y),
		.target_x(target_x), .target_y(target_y),
		.result_valid(result_valid), .result_stall(result_stall),
		.unit_x(unit_x), .unit_y(unit_y), .zero_length(zero_length)
	);

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r, b, x;
		r = 0;
		x = v;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic direction_t normalise(input logic signed [CW-1:0] ox, oy, tx, ty);
		logic signed [CW:0] dx, dy;
		logic [63:0] ax, ay, m, s, len;
		logic [63:0] qx, qy;
		int bl;
		direction_t d;
		dx = $signed({ox[CW-1], ox}) - $signed({tx[CW-1], tx});
		dy = $signed({oy[CW-1], oy}) - $signed({ty[CW-1], ty});
		ax = dx < 0 ? 64'(-dx) : 64'(dx);
		ay = dy < 0 ? 64'(-dy) : 64'(dy);
		m = ax > ay ? ax : ay;
		d = '0;
		if (m == 0) begin
			d.zl = 1'b1;
			return d;
		end
		bl = 0;
		for (int i = 0; i < 64; i++) if (m[i]) bl = i + 1;
		if (bl > NORM_W) begin
			ax >>= bl - NORM_W;
			ay >>= bl - NORM_W;
		end else if (bl < NORM_W) begin
			ax <<= NORM_W - bl;
			ay <<= NORM_W - bl;
		end
		s = ax * ax + ay * ay;
		len = root64(s);
		qx = ((ax << FRAC_OUT) + (len >> 1)) / len;
		qy = ((ay << FRAC_OUT) + (len >> 1)) / len;
		d.ux = dx < 0 ? OUT_W'(-qx) : OUT_W'(qx);
		d.uy = dy < 0 ? OUT_W'(-qy) : OUT_W'(qy);
		return d;
	endfunction

	class direction_scoreboard;
		direction_t pending[$];

		function void note_item(input logic signed [CW-1:0] ox, oy, tx, ty);
			pending.push_back(normalise(ox, oy, tx, ty));
		endfunction

		task check_result(input logic [OUT_W-1:0] ux, uy, input logic zl);
			direction_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected beat", ux, 0);
				return;
			end
			want = pending.pop_front();
			if (ux !== want.ux) report_mismatch("unit_x", ux, want.ux);
			if (uy !== want.uy) report_mismatch("unit_y", uy, want.uy);
			if (zl !== want.zl) report_mismatch("zero_length", zl, want.zl);
		endtask
	endclass

	direction_scoreboard board = new();

	function automatic bit idle_now();
		return !quiet && $urandom_range(99) < 12;
	endfunction

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			board.note_item(origin_x, origin_y, target_x, target_y);
			n_beats++;
		end
		if (arst_n && result_valid && !result_stall) begin
			if (zero_length) n_zero++;
			board.check_result(unit_x, unit_y, zero_length);
		end
	end

	always @(negedge clk) result_stall <= arst_n ? idle_now() : 1'b0;

	task automatic send_pair(input logic [CW-1:0] ox, oy, tx, ty);
		while (idle_now()) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		origin_x <= ox;
		origin_y <= oy;
		target_x <= tx;
		target_y <= ty;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(3))
			0: return CW'($urandom);
			1: return CW'($signed($urandom_range(2000)) - 1000);
			2: return $urandom_range(1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			default: return CW'($signed($urandom_range(1 << 20)) - (1 << 19)) << 8;
		endcase
	endfunction

	localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};

	initial begin
		logic [CW-1:0] p, q;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_pair(0, 0, 0, 0);
		send_pair(MAXP, MAXP, MAXP, MAXP);
		send_pair(MINN, 0, MINN, 0);
		send_pair(MAXP, MAXP, MINN, MINN);
		send_pair(MINN, MINN, MAXP, MAXP);
		send_pair(MAXP, MINN, MINN, MAXP);
		send_pair(1, 0, 0, 0);
		send_pair(0, 0, 1, 0);
		send_pair(0, 1, 0, 0);
		send_pair(0, 0, 0, 1);
		send_pair(1, 1, 0, 0);
		send_pair(3, 4, 0, 0);
		send_pair(0, 0, 3, 4);
		send_pair(32'h0001_0000, 0, 0, 32'h0001_0000);
		send_pair(MAXP, 0, MINN, 1);
		send_pair(1, MAXP, 0, MINN);
		send_pair('1, '1, '1, '1);
		send_pair('1, 0, 0, '1);
		quiet = 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300) quiet = 1'b0;
			if ($urandom_range(19) == 0) begin
				p = rand_coord();
				q = rand_coord();
				send_pair(p, q, p, q);
			end else begin
				send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			end
		end
		item_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("run covered %0d beats, %0d with coinciding points", n_beats, n_zero);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end
endmodule
